FILE: hdl/slsn_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and helpers of the source line splice normalizer
// no dependencies; imported by every other file of the block

package slsn_pkg;

  localparam int BYTE_BITS       = 8;
  localparam int TAB_BITS        = 5;
  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int PLAN_SLOTS      = 4;
  localparam int APB_ADDR_BITS   = 3;
  localparam int APB_DATA_BITS   = 32;

  // character codes
  localparam logic [BYTE_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_BITS-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_BITS-1:0] BOM_B0    = 8'hef;
  localparam logic [BYTE_BITS-1:0] BOM_B1    = 8'hbb;
  localparam logic [BYTE_BITS-1:0] BOM_B2    = 8'hbf;

  // register indexes
  localparam logic [0:0] REG_TAB_WIDTH = 1'b0;
  localparam logic [0:0] REG_BOM_STRIP = 1'b1;

  localparam logic [TAB_BITS-1:0] TAB_WIDTH_RESET = 5'd4;

  // held byte codes
  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_BSL    = 2'd1;
  localparam logic [1:0] HELD_CR     = 2'd2;
  localparam logic [1:0] HELD_BSL_CR = 2'd3;

  // result event kinds
  localparam logic [1:0] EV_CHAR  = 2'd0;
  localparam logic [1:0] EV_CR_LF = 2'd1;
  localparam logic [1:0] EV_EOF   = 2'd2;

  typedef struct packed {
    logic [TAB_BITS-1:0] tab_width;
    logic                bom_strip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [BYTE_BITS-1:0] ch;
  } event_t;

  // results that one accepted item causes, in order
  typedef struct packed {
    logic                        valid;
    logic                        pre_splice;
    logic [2:0]                  n;
    event_t [PLAN_SLOTS-1:0]     slots;
  } plan_t;

  function automatic logic [BYTE_BITS-1:0] bom_byte(input logic [1:0] idx);
    logic [BYTE_BITS-1:0] b;
    unique case (idx)
      2'd0:    b = BOM_B0;
      2'd1:    b = BOM_B1;
      2'd2:    b = BOM_B2;
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/slsn_byte_if.sv
`timescale 1ns / 1ps
// input channel of the normalizer: one raw source byte or an end mark per item
// depends on slsn_pkg

interface slsn_byte_if import slsn_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 is_end;

  modport source(output valid, in_byte, is_end, input ready);
  modport sink(input valid, in_byte, is_end, output ready);
endinterface

FILE: hdl/slsn_char_if.sv
`timescale 1ns / 1ps
// output channel of the normalizer: one character with its line and column per item
// depends on slsn_pkg

interface slsn_char_if import slsn_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [BYTE_BITS-1:0]   out_char;
  logic                   is_eof;
  logic [LINE_BITS-1:0]   line_no;
  logic [COLUMN_BITS-1:0] column_no;
  logic                   last;

  modport source(output valid, out_char, is_eof, line_no, column_no, last, input ready);
  modport sink(input valid, out_char, is_eof, line_no, column_no, last, output ready);
endinterface

FILE: hdl/slsn_cfg.sv
`timescale 1ns / 1ps
// apb register file: tab width and byte order mark switch
// depends on slsn_pkg

module slsn_cfg import slsn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic [0:0] reg_sel;
  logic       wr;

  assign reg_sel = paddr[APB_ADDR_BITS-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tab_width <= TAB_WIDTH_RESET;
      cfg.bom_strip <= 1'b1;
    end else if (wr) begin
      unique case (reg_sel)
        REG_TAB_WIDTH: cfg.tab_width <= pwdata[TAB_BITS-1:0];
        REG_BOM_STRIP: cfg.bom_strip <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TAB_WIDTH: prdata = {{(APB_DATA_BITS-TAB_BITS){1'b0}}, cfg.tab_width};
      REG_BOM_STRIP: prdata = {{(APB_DATA_BITS-1){1'b0}}, cfg.bom_strip};
    endcase
  end

endmodule

FILE: hdl/slsn_decode.sv
`timescale 1ns / 1ps
// byte decoder: mark matching, held backslash and cr, builds the result plan
// depends on slsn_pkg and slsn_byte_if

module slsn_decode import slsn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  slsn_byte_if.sink   byte_chan,
  input  cfg_t        cfg,
  input  logic        plan_done,
  output plan_t       plan
);

  typedef struct packed {
    logic           splice;
    logic [1:0]     n;
    event_t [1:0]   ev;
    logic [1:0]     held;
  } feed_t;

  logic [1:0] held, held_next;
  logic [1:0] bom_count, bom_count_next;
  logic       at_start, at_start_next;
  logic       ended, ended_next;
  plan_t      plan_next;
  feed_t      fr;
  logic       end_in;
  logic       do_feed;
  logic       accept;
  logic [BYTE_BITS-1:0] c;

  // one raw byte through the held-byte logic: at most a splice and two characters
  function automatic feed_t feed(input logic [BYTE_BITS-1:0] b, input logic [1:0] h);
    feed_t r;
    logic  tail;
    r    = '0;
    tail = 1'b0;
    unique case (h)
      HELD_NONE: tail = 1'b1;
      HELD_BSL: begin
        if (b == CH_LF) begin
          r.splice = 1'b1;
        end else if (b == CH_CR) begin
          r.held = HELD_BSL_CR;
        end else begin
          r.ev[0] = {EV_CHAR, CH_BSLASH};
          r.n     = 2'd1;
          tail    = 1'b1;
        end
      end
      HELD_CR: begin
        r.ev[0] = {EV_CR_LF, CH_LF};
        r.n     = 2'd1;
        tail    = (b != CH_LF);
      end
      HELD_BSL_CR: begin
        r.splice = 1'b1;
        tail     = (b != CH_LF);
      end
    endcase
    if (tail) begin
      if (b == CH_BSLASH) begin
        r.held = HELD_BSL;
      end else if (b == CH_CR) begin
        r.held = HELD_CR;
      end else begin
        r.ev[r.n[0]] = {EV_CHAR, b};
        r.n          = r.n + 2'd1;
      end
    end
    return r;
  endfunction

  assign c      = byte_chan.in_byte;
  assign end_in = byte_chan.is_end || (c == CH_NUL);
  assign fr     = feed(c, held);
  assign byte_chan.ready = !plan.valid || plan_done;
  assign accept = byte_chan.valid && byte_chan.ready;

  always_comb begin
    plan_next       = '0;
    plan_next.valid = 1'b1;
    held_next       = held;
    bom_count_next  = bom_count;
    at_start_next   = at_start;
    ended_next      = ended;
    do_feed         = 1'b0;

    if (ended) begin
      plan_next.slots[0] = {EV_EOF, CH_NUL};
      plan_next.n        = 3'd1;
    end else if (end_in) begin
      // matched mark bytes go out as plain characters, then held bytes, then the end
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < bom_count) begin
          plan_next.slots[plan_next.n[1:0]] = {EV_CHAR, bom_byte(2'(k))};
          plan_next.n = plan_next.n + 3'd1;
        end
      end
      unique case (held)
        HELD_NONE: ;
        HELD_BSL: begin
          plan_next.slots[plan_next.n[1:0]] = {EV_CHAR, CH_BSLASH};
          plan_next.n = plan_next.n + 3'd1;
        end
        HELD_CR: begin
          plan_next.slots[plan_next.n[1:0]] = {EV_CR_LF, CH_LF};
          plan_next.n = plan_next.n + 3'd1;
        end
        HELD_BSL_CR: plan_next.pre_splice = 1'b1;
      endcase
      plan_next.slots[plan_next.n[1:0]] = {EV_EOF, CH_NUL};
      plan_next.n    = plan_next.n + 3'd1;
      held_next      = HELD_NONE;
      bom_count_next = 2'd0;
      at_start_next  = 1'b0;
      ended_next     = 1'b1;
    end else if (at_start) begin
      priority if (bom_count == 2'd0 && !cfg.bom_strip) begin
        at_start_next = 1'b0;
        do_feed       = 1'b1;
      end else if (bom_count == 2'd3) begin
        // full mark followed by a fourth byte: mark dropped
        bom_count_next = 2'd0;
        at_start_next  = 1'b0;
        do_feed        = 1'b1;
      end else if (c == bom_byte(bom_count)) begin
        bom_count_next = bom_count + 2'd1;
      end else begin
        // broken mark: matched bytes become plain characters
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < bom_count) begin
            plan_next.slots[plan_next.n[1:0]] = {EV_CHAR, bom_byte(2'(k))};
            plan_next.n = plan_next.n + 3'd1;
          end
        end
        bom_count_next = 2'd0;
        at_start_next  = 1'b0;
        do_feed        = 1'b1;
      end
    end else begin
      do_feed = 1'b1;
    end

    if (do_feed) begin
      held_next            = fr.held;
      plan_next.pre_splice = fr.splice;
      for (int k = 0; k < 2; k++) begin
        if (2'(k) < fr.n) begin
          plan_next.slots[plan_next.n[1:0]] = fr.ev[k];
          plan_next.n = plan_next.n + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= HELD_NONE;
      bom_count  <= 2'd0;
      at_start   <= 1'b1;
      ended      <= 1'b0;
      plan.valid <= 1'b0;
    end else if (accept) begin
      held      <= held_next;
      bom_count <= bom_count_next;
      at_start  <= at_start_next;
      ended     <= ended_next;
      plan      <= plan_next;
    end else if (plan_done) begin
      plan.valid <= 1'b0;
    end
  end

  a_ended_sticky: assert property (@(posedge clk) disable iff (rst) ended |=> ended)
    else $error("end state left without reset");
  a_mark_only_at_start: assert property (@(posedge clk) disable iff (rst)
    !at_start |-> (bom_count == 2'd0))
    else $error("mark count nonzero after start");
  a_held_after_start: assert property (@(posedge clk) disable iff (rst)
    (held != HELD_NONE) |-> !at_start)
    else $error("byte held while mark still pending");

endmodule

FILE: hdl/slsn_emit.sv
`timescale 1ns / 1ps
// result emitter: walks the plan one result per cycle unless char_chan stalls, keeps line and column
// depends on slsn_pkg and slsn_char_if

module slsn_emit import slsn_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  plan_t       plan,
  output logic        plan_done,
  slsn_char_if.source char_chan
);

  logic [LINE_BITS-1:0]   line, line_next, l1;
  logic [COLUMN_BITS-1:0] col, col_next, c1, c2;
  logic                   pend, pend_next, p1;
  logic [1:0]             idx;
  logic                   out_valid;
  logic                   room, step, empty_plan, last_slot, do_splice, is_eof;
  event_t                 cur;
  logic [TAB_BITS-1:0]    adv;
  logic [COLUMN_BITS:0]   col_sum;

  function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] v);
    return (v == '1) ? v : v + LINE_BITS'(1);
  endfunction

  assign cur        = plan.slots[idx];
  assign empty_plan = (plan.n == 3'd0);
  assign last_slot  = ({1'b0, idx} + 3'd1) == plan.n;
  assign room       = !out_valid || char_chan.ready;
  assign step       = plan.valid && (empty_plan || room);
  assign plan_done  = step && (empty_plan || last_slot);
  assign do_splice  = plan.pre_splice && (idx == 2'd0);
  assign is_eof     = cur.kind == EV_EOF;

  // splice first where the plan opens with one
  always_comb begin
    l1 = (do_splice && pend) ? sat_inc(line) : line;
    c1 = (do_splice && pend) ? '0 : col;
    p1 = do_splice || pend;
  end

  // then the character itself
  always_comb begin
    adv     = (cur.kind == EV_CR_LF) ? '0 :
              (cur.ch == CH_TAB)     ? cfg.tab_width : TAB_BITS'(1);
    c2      = p1 ? '0 : c1;
    col_sum = {1'b0, c2} + (COLUMN_BITS+1)'(adv);
    if (empty_plan || is_eof) begin
      line_next = l1;
      col_next  = c1;
      pend_next = p1;
    end else begin
      line_next = p1 ? sat_inc(l1) : l1;
      col_next  = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
      pend_next = (cur.ch == CH_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line      <= LINE_BITS'(1);
      col       <= '0;
      pend      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        line <= line_next;
        col  <= col_next;
        pend <= pend_next;
        idx  <= plan_done ? 2'd0 : idx + 2'd1;
      end
      if (step && !empty_plan) begin
        out_valid <= 1'b1;
      end else if (char_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !empty_plan) begin
      char_chan.out_char  <= cur.ch;
      char_chan.is_eof    <= is_eof;
      char_chan.line_no   <= line_next;
      char_chan.column_no <= col_next;
      char_chan.last      <= last_slot;
    end
  end

  assign char_chan.valid = out_valid;

  a_idx_in_plan: assert property (@(posedge clk) disable iff (rst)
    (plan.valid && !empty_plan) |-> ({1'b0, idx} < plan.n))
    else $error("slot index past plan count");
  a_line_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (line >= $past(line)))
    else $error("line count went down");
  a_eof_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_chan.is_eof) |-> char_chan.last)
    else $error("end result not final for its item");

endmodule

FILE: hdl/source_line_splice_normalizer.sv
`timescale 1ns / 1ps
// top level of the source line splice normalizer
// depends on slsn_pkg, slsn_byte_if, slsn_char_if, slsn_cfg, slsn_decode, slsn_emit

// Takes raw source bytes on byte_chan and gives normalized characters on char_chan,
// each with its physical line (from 1) and the column after it, both saturating.
// A leading EF BB BF mark is dropped when bom_strip is set and a fourth byte follows;
// backslash plus LF, CR or CR LF is spliced out; CR and CR LF become LF. A zero byte
// or is_end flushes held bytes and gives an end result (is_eof), and every later item
// gives one more end result. An accepted item is decoded into a plan of up to four
// results held in one register; the emitter sends one result per cycle from it while
// char_chan is not stalled, and the input is held until the last one is taken. Plain
// text thus runs at one byte per cycle while char_chan is ready. Each result passes
// through the plan register and then the result register. last marks the final
// result of each item. tab_width (address 0) and bom_strip (address 4) are to be
// written over the APB port only while the block is idle; nothing enforces this.

module source_line_splice_normalizer import slsn_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  slsn_byte_if.sink                byte_chan,
  slsn_char_if.source              char_chan,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t  cfg;
  plan_t plan;
  logic  plan_done;

  // configuration registers
  slsn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // mark, backslash and cr handling; fills the plan register
  slsn_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .cfg       (cfg),
    .plan_done (plan_done),
    .plan      (plan)
  );

  // line and column tracking, result register
  slsn_emit #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .plan      (plan),
    .plan_done (plan_done),
    .char_chan (char_chan)
  );

endmodule
